@@ hw/rtl/ptt_pkg.sv @@
// Package for the pending request timeout table.
// Holds sizes, status and command codes, and the shared types.
// No dependencies.
package ptt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RAM_DEPTH   = 1 << ADDR_W;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Must be a power of two: the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int ID_W    = 8;
  localparam int AMT_W   = 16;
  localparam int STEP_W  = 8;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 3;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STREAM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESP   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

  localparam logic [ID_W-1:0] ID_I = 8'h49;
  localparam logic [ID_W-1:0] ID_S = 8'h53;
  localparam logic [ID_W-1:0] ID_R = 8'h52;
  localparam logic [ID_W-1:0] ID_H = 8'h48;
  localparam logic [ID_W-1:0] ID_C = 8'h43;

  localparam logic [STAT_W-1:0] ST_ACCEPTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ID     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] ST_MATCHED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNEXPECTED = 3'd4;
  localparam logic [STAT_W-1:0] ST_EXPIRED    = 3'd5;
  localparam logic [STAT_W-1:0] ST_TICK_DONE  = 3'd6;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_BAD_ID,
    OP_RESP,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [AMT_W-1:0]  amount;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/pending_request_timeout_table_top.sv @@
// Top level of the pending request timeout table.
// Front end, command queue and back end; uses ptt_pkg, ptt_front,
// ptt_queue and ptt_back.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o    mode_i, request_id_i,
//                                                 timeout_amount_i, tick_step_i
//   out      from block out_valid_o / out_stall_i  status_o, result_id_o, last_o
//
// A request or a bad identifier is handled straight from the back end's idle
// state. A response or a tick walks the table one entry a cycle through the
// RAM read port, except while a result waits on an output stall.
// The front end and a two-deep queue keep taking items while the back end
// works. Reset empties the table and the queue; RAM contents are kept.
// An output stall holds the result register and any back-end step that emits.
module pending_request_timeout_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptt_pkg::MODE_W-1:0]    mode_i,
  input  logic [ptt_pkg::ID_W-1:0]      request_id_i,
  input  logic [ptt_pkg::AMT_W-1:0]     timeout_amount_i,
  input  logic [ptt_pkg::STEP_W-1:0]    tick_step_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ptt_pkg::STAT_W-1:0]    status_o,
  output logic [ptt_pkg::ID_W-1:0]      result_id_o,
  output logic                          last_o
);

  logic          push, q_full, q_valid, pop;
  ptt_pkg::cmd_t front_cmd, q_cmd;

  ptt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .request_id_i     (request_id_i),
    .timeout_amount_i (timeout_amount_i),
    .tick_step_i      (tick_step_i),
    .push_o           (push),
    .cmd_o            (front_cmd),
    .q_full_i         (q_full)
  );

  ptt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  ptt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .result_id_o (result_id_o),
    .last_o      (last_o)
  );

endmodule

@@ hw/rtl/ptt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ptt_front.sv @@
// Front end: takes input items, checks identifiers against the mode and
// registers the classified command for the queue. Uses ptt_pkg.
module ptt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptt_pkg::MODE_W-1:0]    mode_i,
  input  logic [ptt_pkg::ID_W-1:0]      request_id_i,
  input  logic [ptt_pkg::AMT_W-1:0]     timeout_amount_i,
  input  logic [ptt_pkg::STEP_W-1:0]    tick_step_i,
  output logic                          push_o,
  output ptt_pkg::cmd_t                 cmd_o,
  input  logic                          q_full_i
);

  logic          hold_q, hold_d;
  ptt_pkg::cmd_t cmd_q, cmd_d;
  logic          take;
  logic          plain_ok, stream_ok;

  assign in_stall_o = hold_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = hold_q && !q_full_i;
  assign cmd_o      = cmd_q;

  assign plain_ok  = (request_id_i == ptt_pkg::ID_I) || (request_id_i == ptt_pkg::ID_S) ||
                     (request_id_i == ptt_pkg::ID_R);
  assign stream_ok = (request_id_i == ptt_pkg::ID_H) || (request_id_i == ptt_pkg::ID_C);

  always_comb begin
    cmd_d.id     = request_id_i;
    cmd_d.amount = timeout_amount_i;
    cmd_d.step   = tick_step_i;
    unique case (mode_i)
      ptt_pkg::MODE_PLAIN:  cmd_d.op = plain_ok ? ptt_pkg::OP_REQ : ptt_pkg::OP_BAD_ID;
      ptt_pkg::MODE_STREAM: cmd_d.op = stream_ok ? ptt_pkg::OP_REQ : ptt_pkg::OP_BAD_ID;
      ptt_pkg::MODE_RESP:   cmd_d.op = ptt_pkg::OP_RESP;
      default:              cmd_d.op = ptt_pkg::OP_TICK;
    endcase
  end

  always_comb begin
    hold_d = hold_q;
    if (take) begin
      hold_d = 1'b1;
    end else if (push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

@@ hw/rtl/ptt_queue.sv @@
// Short command queue between front and back end.
// Uses ptt_pkg.
module ptt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptt_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output ptt_pkg::cmd_t cmd_o,
  input  logic          pop_i
);

  ptt_pkg::cmd_t                   mem_q [ptt_pkg::QUEUE_DEPTH];
  logic [ptt_pkg::QUEUE_AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [ptt_pkg::QUEUE_AW:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == (ptt_pkg::QUEUE_AW+1)'(ptt_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? wp_q + 1'b1 : wp_q;
    rp_d  = do_pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

@@ hw/rtl/ptt_back.sv @@
// Back end: sequencer over the entry RAM and the result register.
// Scans, compacts and appends entries. Uses ptt_pkg and ptt_ram.
module ptt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  ptt_pkg::cmd_t                 q_cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ptt_pkg::STAT_W-1:0]    status_o,
  output logic [ptt_pkg::ID_W-1:0]      result_id_o,
  output logic                          last_o
);

  localparam logic [1:0] S_IDLE      = 2'd0;
  localparam logic [1:0] S_RSP_SCAN  = 2'd1;
  localparam logic [1:0] S_RSP_SHIFT = 2'd2;
  localparam logic [1:0] S_TICK      = 2'd3;

  logic [1:0]      state_q, state_d;
  ptt_pkg::cnt_t   count_q, count_d;
  ptt_pkg::cnt_t   rd_q, rd_d, wr_q, wr_d, rd_next;
  ptt_pkg::cmd_t   cur_q, cur_d;

  logic            we;
  ptt_pkg::addr_t  waddr, raddr;
  ptt_pkg::entry_t wdata, rdata;
  logic [ptt_pkg::ENTRY_W-1:0] rdata_raw;
  logic [ptt_pkg::AMT_W-1:0]   step_ext;

  logic                       out_valid_q, out_valid_d, out_free;
  logic                       emit, emit_last;
  logic [ptt_pkg::STAT_W-1:0] emit_st, status_q;
  logic [ptt_pkg::ID_W-1:0]   emit_id, id_q;
  logic                       last_q;

  ptt_ram #(
    .WIDTH (ptt_pkg::ENTRY_W),
    .DEPTH (ptt_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata    = rdata_raw;
  assign rd_next  = rd_q + ptt_pkg::cnt_t'(1);
  assign step_ext = {{(ptt_pkg::AMT_W-ptt_pkg::STEP_W){1'b0}}, cur_q.step};
  assign out_free = !out_valid_q || !out_stall_i;

  // Read data in the scan states belongs to entry rd_q; the address for the
  // next cycle is rd_q + 1 when moving on and rd_q again when held.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    cur_d     = cur_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = wr_q[ptt_pkg::ADDR_W-1:0];
    wdata     = rdata;
    raddr     = '0;
    emit      = 1'b0;
    emit_st   = ptt_pkg::ST_ACCEPTED;
    emit_id   = cur_q.id;
    emit_last = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            ptt_pkg::OP_BAD_ID: begin
              if (out_free) begin
                pop_o   = 1'b1;
                emit    = 1'b1;
                emit_st = ptt_pkg::ST_BAD_ID;
                emit_id = q_cmd_i.id;
              end
            end
            ptt_pkg::OP_REQ: begin
              if (out_free) begin
                pop_o   = 1'b1;
                emit    = 1'b1;
                emit_id = q_cmd_i.id;
                if (count_q >= ptt_pkg::cnt_t'(ptt_pkg::TABLE_DEPTH)) begin
                  emit_st = ptt_pkg::ST_FULL;
                end else begin
                  we              = 1'b1;
                  waddr           = count_q[ptt_pkg::ADDR_W-1:0];
                  wdata.id        = q_cmd_i.id;
                  wdata.remaining = q_cmd_i.amount;
                  count_d         = count_q + ptt_pkg::cnt_t'(1);
                  emit_st         = ptt_pkg::ST_ACCEPTED;
                end
              end
            end
            ptt_pkg::OP_RESP: begin
              pop_o   = 1'b1;
              cur_d   = q_cmd_i;
              rd_d    = '0;
              state_d = S_RSP_SCAN;
            end
            default: begin
              pop_o   = 1'b1;
              cur_d   = q_cmd_i;
              rd_d    = '0;
              wr_d    = '0;
              state_d = S_TICK;
            end
          endcase
        end
      end
      S_RSP_SCAN: begin
        if (rd_q >= count_q) begin
          if (out_free) begin
            emit    = 1'b1;
            emit_st = ptt_pkg::ST_UNEXPECTED;
            state_d = S_IDLE;
          end
        end else if (rdata.id == cur_q.id) begin
          wr_d    = rd_q;
          rd_d    = rd_next;
          raddr   = rd_next[ptt_pkg::ADDR_W-1:0];
          state_d = S_RSP_SHIFT;
        end else begin
          rd_d  = rd_next;
          raddr = rd_next[ptt_pkg::ADDR_W-1:0];
        end
      end
      S_RSP_SHIFT: begin
        if (rd_q >= count_q) begin
          if (out_free) begin
            emit    = 1'b1;
            emit_st = ptt_pkg::ST_MATCHED;
            count_d = count_q - ptt_pkg::cnt_t'(1);
            state_d = S_IDLE;
          end
        end else begin
          we    = 1'b1;
          wr_d  = wr_q + ptt_pkg::cnt_t'(1);
          rd_d  = rd_next;
          raddr = rd_next[ptt_pkg::ADDR_W-1:0];
        end
      end
      S_TICK: begin
        if (rd_q >= count_q) begin
          if (out_free) begin
            emit    = 1'b1;
            emit_st = ptt_pkg::ST_TICK_DONE;
            emit_id = '0;
            count_d = wr_q;
            state_d = S_IDLE;
          end
        end else if (rdata.remaining <= step_ext) begin
          raddr = rd_q[ptt_pkg::ADDR_W-1:0];
          if (out_free) begin
            emit      = 1'b1;
            emit_st   = ptt_pkg::ST_EXPIRED;
            emit_id   = rdata.id;
            emit_last = 1'b0;
            rd_d      = rd_next;
            raddr     = rd_next[ptt_pkg::ADDR_W-1:0];
          end
        end else begin
          we              = 1'b1;
          wdata.remaining = rdata.remaining - step_ext;
          wr_d            = wr_q + ptt_pkg::cnt_t'(1);
          rd_d            = rd_next;
          raddr           = rd_next[ptt_pkg::ADDR_W-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      status_q <= emit_st;
      id_q     <= emit_id;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_id_o = id_q;
  assign last_o      = last_q;

endmodule

@@ bench/pending_request_timeout_table_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pending_request_timeout_table_top: directed and random
// requests, responses and ticks against a behavioural copy of the table.
// Depends on ptt_pkg and the RTL of the block only.
module pending_request_timeout_table_top_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int PRESSURE_AT = 35;
  localparam int WATCHDOG    = 4000;
  localparam int RANDOM_ITEMS = 154;

  typedef struct packed {
    logic [ptt_pkg::MODE_W-1:0] mode;
    logic [ptt_pkg::ID_W-1:0]   id;
    logic [ptt_pkg::AMT_W-1:0]  amount;
    logic [ptt_pkg::STEP_W-1:0] step;
  } req_item_t;

  typedef struct packed {
    logic [ptt_pkg::STAT_W-1:0] status;
    logic [ptt_pkg::ID_W-1:0]   id;
    logic                       last;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [ptt_pkg::MODE_W-1:0] mode_i = '0;
  logic [ptt_pkg::ID_W-1:0]   request_id_i = '0;
  logic [ptt_pkg::AMT_W-1:0]  timeout_amount_i = '0;
  logic [ptt_pkg::STEP_W-1:0] tick_step_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [ptt_pkg::STAT_W-1:0] status_o;
  logic [ptt_pkg::ID_W-1:0]   result_id_o;
  logic                       last_o;

  pending_request_timeout_table_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .request_id_i     (request_id_i),
    .timeout_amount_i (timeout_amount_i),
    .tick_step_i      (tick_step_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_id_o      (result_id_o),
    .last_o           (last_o)
  );

  // Shadow copy of the table, oldest entry at index 0
  logic [ptt_pkg::ID_W-1:0]  tbl_id   [ptt_pkg::TABLE_DEPTH];
  logic [ptt_pkg::AMT_W-1:0] tbl_left [ptt_pkg::TABLE_DEPTH];
  int                        tbl_count = 0;

  req_item_t pending_items[$];
  outcome_t  expected_outcomes[$];
  req_item_t driven_item;

  int total_items = 1;
  int items_taken = 0;
  int outcomes_seen = 0;
  int errors = 0;
  int full_hits = 0;
  int expiries = 0;
  int longest_burst = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Four quarters of the run: no idling, sender gaps, receiver stalls, both
  function automatic int idle_pct(input bit rx);
    int phase;
    phase = items_taken * 4 / total_items;
    case (phase)
      1: return rx ? 0 : 47;
      2: return rx ? 47 : 0;
      3: return 32;
      default: return 0;
    endcase
  endfunction

  function automatic logic [ptt_pkg::ID_W-1:0] good_id(input bit stream);
    if (stream) return $urandom_range(1) ? ptt_pkg::ID_H : ptt_pkg::ID_C;
    case ($urandom_range(2))
      0: return ptt_pkg::ID_I;
      1: return ptt_pkg::ID_S;
      default: return ptt_pkg::ID_R;
    endcase
  endfunction

  task automatic push_item(input logic [ptt_pkg::MODE_W-1:0] mode,
                           input logic [ptt_pkg::ID_W-1:0] id,
                           input logic [ptt_pkg::AMT_W-1:0] amount,
                           input logic [ptt_pkg::STEP_W-1:0] step);
    req_item_t it;
    it.mode   = mode;
    it.id     = id;
    it.amount = amount;
    it.step   = step;
    pending_items = {pending_items, it};
  endtask

  // Works out the results of one transfer into the table and updates the shadow
  task automatic table_outcomes(input req_item_t it);
    outcome_t o;
    outcome_t ex;
    bit       id_ok;
    int       wr;
    int       hit;
    int       n;
    n = 0;
    o.last = 1'b1;
    o.id = it.id;
    case (it.mode)
      ptt_pkg::MODE_PLAIN, ptt_pkg::MODE_STREAM: begin
        if (it.mode == ptt_pkg::MODE_PLAIN)
          id_ok = (it.id == ptt_pkg::ID_I) || (it.id == ptt_pkg::ID_S) ||
                  (it.id == ptt_pkg::ID_R);
        else
          id_ok = (it.id == ptt_pkg::ID_H) || (it.id == ptt_pkg::ID_C);
        if (!id_ok) begin
          o.status = ptt_pkg::ST_BAD_ID;
        end else if (tbl_count >= ptt_pkg::TABLE_DEPTH) begin
          o.status = ptt_pkg::ST_FULL;
          full_hits++;
        end else begin
          tbl_id[tbl_count]   = it.id;
          tbl_left[tbl_count] = it.amount;
          tbl_count++;
          o.status = ptt_pkg::ST_ACCEPTED;
        end
      end
      ptt_pkg::MODE_RESP: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_id[i] == it.id) hit = i;
        end
        if (hit < 0) begin
          o.status = ptt_pkg::ST_UNEXPECTED;
        end else begin
          for (int j = hit; j + 1 < tbl_count; j++) begin
            tbl_id[j]   = tbl_id[j+1];
            tbl_left[j] = tbl_left[j+1];
          end
          tbl_count--;
          o.status = ptt_pkg::ST_MATCHED;
        end
      end
      default: begin
        // Every entry is looked at once; survivors are packed towards the old end
        wr = 0;
        for (int rd = 0; rd < tbl_count; rd++) begin
          if (tbl_left[rd] <= {8'd0, it.step}) begin
            ex.status = ptt_pkg::ST_EXPIRED;
            ex.id     = tbl_id[rd];
            ex.last   = 1'b0;
            expected_outcomes = {expected_outcomes, ex};
            expiries++;
            n++;
          end else begin
            tbl_id[wr]   = tbl_id[rd];
            tbl_left[wr] = tbl_left[rd] - {8'd0, it.step};
            wr++;
          end
        end
        tbl_count = wr;
        o.status = ptt_pkg::ST_TICK_DONE;
        o.id = '0;
      end
    endcase
    expected_outcomes = {expected_outcomes, o};
    n++;
    if (n > longest_burst) longest_burst = n;
  endtask

  // Driver: offers the next item once the previous one has been taken, with random gaps in some quarters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      mode_i           <= '0;
      request_id_i     <= '0;
      timeout_amount_i <= '0;
      tick_step_i      <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        table_outcomes(driven_item);
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          driven_item = pending_items.pop_front();
          in_valid_i       <= 1'b1;
          mode_i           <= driven_item.mode;
          request_id_i     <= driven_item.id;
          timeout_amount_i <= driven_item.amount;
          tick_step_i      <= driven_item.step;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    outcome_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        outcomes_seen++;
        if (expected_outcomes.size() == 0) begin
          $error("result with nothing expected: status %0d, result_id 0x%02h, last %0b",
                 status_o, result_id_o, last_o);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (result_id_o !== want.id) begin
            $error("result_id: expected 0x%02h, got 0x%02h", want.id, result_id_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            errors++;
          end
        end
      end
      // One long hold-off while the sender keeps pushing, to back the block up
      if (!pressure_done && items_taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct(1'b1));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int n;
    int count;
    logic [ptt_pkg::ID_W-1:0] ids [5];
    bit stream;
    ids = '{ptt_pkg::ID_I, ptt_pkg::ID_S, ptt_pkg::ID_R, ptt_pkg::ID_H, ptt_pkg::ID_C};

    // Directed: empty table, bad ids at the byte extremes, fill to the brim,
    // full and bad id while full, zero budget on a zero step, then a big tick
    push_item(ptt_pkg::MODE_TICK, 8'h00, 16'h0000, 8'd0);
    push_item(ptt_pkg::MODE_RESP, ptt_pkg::ID_I, 16'hFFFF, 8'hFF);
    push_item(ptt_pkg::MODE_PLAIN, 8'hFF, 16'h1234, 8'h00);
    push_item(ptt_pkg::MODE_STREAM, 8'h00, 16'h0040, 8'h00);
    for (int i = 0; i < ptt_pkg::TABLE_DEPTH; i++) begin
      stream = (i % 5) >= 3;
      push_item(stream ? ptt_pkg::MODE_STREAM : ptt_pkg::MODE_PLAIN, ids[i % 5],
                (i == 0) ? 16'd0 : (i == 1) ? 16'd1 : (i == 2) ? 16'd255
                                 : 16'($urandom_range(254, 2)),
                8'($urandom_range(255)));
    end
    push_item(ptt_pkg::MODE_PLAIN, ptt_pkg::ID_I, 16'hFFFF, 8'h00);
    push_item(ptt_pkg::MODE_STREAM, ptt_pkg::ID_S, 16'h0010, 8'h00);
    push_item(ptt_pkg::MODE_TICK, ptt_pkg::ID_H, 16'hFFFF, 8'd0);
    push_item(ptt_pkg::MODE_RESP, ptt_pkg::ID_R, 16'h0000, 8'h00);
    push_item(ptt_pkg::MODE_STREAM, ptt_pkg::ID_H, 16'hFFFF, 8'h00);
    push_item(ptt_pkg::MODE_TICK, 8'hFF, 16'h0000, 8'd255);

    // Random: mostly well-formed traffic, some fill-and-flush bursts and noise
    count = 0;
    while (count < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)));
        count++;
      end else if (r < 14) begin
        n = $urandom_range(17, 8);
        for (int k = 0; k < n; k++) begin
          stream = 1'($urandom_range(1));
          push_item(stream ? ptt_pkg::MODE_STREAM : ptt_pkg::MODE_PLAIN, good_id(stream),
                    16'($urandom_range(255)), 8'($urandom_range(255)));
        end
        push_item(ptt_pkg::MODE_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  $urandom_range(3) != 0 ? 8'd255 : 8'($urandom_range(255)));
        count += n + 1;
      end else if (r < 42) begin
        stream = 1'($urandom_range(1));
        push_item(stream ? ptt_pkg::MODE_STREAM : ptt_pkg::MODE_PLAIN, good_id(stream),
                  $urandom_range(3) == 0 ? 16'($urandom_range(65535))
                                         : 16'($urandom_range(600)),
                  8'($urandom_range(255)));
        count++;
      end else if (r < 52) begin
        push_item(2'($urandom_range(1)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)));
        count++;
      end else if (r < 74) begin
        push_item(ptt_pkg::MODE_RESP,
                  $urandom_range(5) != 0 ? good_id(1'($urandom_range(1)))
                                         : 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)));
        count++;
      end else begin
        push_item(ptt_pkg::MODE_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  $urandom_range(7) == 0 ? 8'd0 : 8'($urandom_range(255)));
        count++;
      end
    end
    total_items = pending_items.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d items and %0d results: %0d expiries, %0d full-table rejects,",
             items_taken, outcomes_seen, expiries, full_hits);
    $display("longest burst from one item %0d results, %0d mismatches.",
             longest_burst, errors);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_queue.sv
hw/rtl/ptt_back.sv
hw/rtl/pending_request_timeout_table_top.sv
bench/pending_request_timeout_table_top_tb.sv
